// ===== rtl/aue_pkg.sv =====
// ----------------------------------------------------------------------------
// aue_pkg
// Shared types and constants for the ALU micro-op encoder.
// ----------------------------------------------------------------------------
package aue_pkg;

    localparam logic [3:0] ACT_RESET    = 4'd0;
    localparam logic [3:0] ACT_MOV      = 4'd1;
    localparam logic [3:0] ACT_MOV_IMM  = 4'd2;
    localparam logic [3:0] ACT_ADD      = 4'd3;
    localparam logic [3:0] ACT_ADD_IMM  = 4'd4;
    localparam logic [3:0] ACT_ADD_LSH  = 4'd5;
    localparam logic [3:0] ACT_AND      = 4'd6;
    localparam logic [3:0] ACT_AND_IMM  = 4'd7;
    localparam logic [3:0] ACT_OR       = 4'd8;
    localparam logic [3:0] ACT_OR_IMM   = 4'd9;
    localparam logic [3:0] ACT_SUB      = 4'd10;
    localparam logic [3:0] ACT_SUB_IMM  = 4'd11;
    localparam logic [3:0] ACT_XOR      = 4'd12;
    localparam logic [3:0] ACT_XOR_IMM  = 4'd13;

    localparam logic [7:0] OPC_AND_R = 8'h00;
    localparam logic [7:0] OPC_EOR_R = 8'h02;
    localparam logic [7:0] OPC_SUB_R = 8'h04;
    localparam logic [7:0] OPC_ADD_R = 8'h08;
    localparam logic [7:0] OPC_ORR_R = 8'h18;
    localparam logic [7:0] OPC_MOV_R = 8'h1a;
    localparam logic [7:0] OPC_AND_I = 8'h20;
    localparam logic [7:0] OPC_EOR_I = 8'h22;
    localparam logic [7:0] OPC_SUB_I = 8'h24;
    localparam logic [7:0] OPC_ADD_I = 8'h28;
    localparam logic [7:0] OPC_ORR_I = 8'h38;
    localparam logic [7:0] OPC_MOV_I = 8'h3a;
    localparam logic [7:0] OPC_BIC_I = 8'h3c;
    localparam logic [7:0] OPC_LDR_I = 8'h51;
    localparam logic [3:0] COND_AL   = 4'he;
    localparam logic [31:0] LDR_UP   = 32'h0080_0000;
    localparam logic [31:0] MIN_NEG  = 32'h8000_0000;

    localparam logic [3:0] CFG_TEMP_REG = 4'd0;
    localparam logic [3:0] CFG_POOL_REG = 4'd1;

    // decode result handed from datapath to controller
    typedef struct packed {
        logic       none;      // no result (reset or unused code)
        logic       direct;    // single word, no literal
        logic       need_lit;  // literal path
        logic       lit_to_d;  // LDR into destination, no following op
    } aue_stat_t;

    // controller commands to datapath
    typedef struct packed {
        logic load;       // capture input beat and decode
        logic clr_pool;   // reset action
        logic srch_start; // init search pointer
        logic srch_step;  // advance search pointer
        logic append;     // write new literal
        logic emit;       // present output beat
        logic [1:0] sel;  // which word to present
        logic last;
    } aue_cmd_t;

    localparam logic [1:0] SEL_DIRECT = 2'd0;
    localparam logic [1:0] SEL_POOL   = 2'd1;
    localparam logic [1:0] SEL_LDR    = 2'd2;
    localparam logic [1:0] SEL_FULL   = 2'd3;

    function automatic logic [31:0] dp_word(input logic [7:0] opc, input logic [3:0] rd,
                                            input logic [3:0] rn, input logic [11:0] low);
        dp_word = {COND_AL, opc, rn, rd, low};
    endfunction

    // 8-bit value with even rotation, trailing zeros stripped by 16/8/4/2
    function automatic logic [12:0] rot_imm(input logic [31:0] val);
        logic [31:0] v;
        logic [4:0]  sh;
        logic [4:0]  rot;
        v  = val;
        sh = 5'd0;
        if (v[15:0] == 16'd0) begin sh = sh + 5'd16; v = v >> 16; end
        if (v[7:0] == 8'd0) begin sh = sh + 5'd8; v = v >> 8; end
        if (v[3:0] == 4'd0) begin sh = sh + 5'd4; v = v >> 4; end
        if (v[1:0] == 2'd0) begin sh = sh + 5'd2; v = v >> 2; end
        rot = 5'd0 - sh;
        rot_imm = {(v[31:8] == 24'd0), rot[4:1], v[7:0]};
    endfunction

endpackage

// ===== rtl/aue_datapath.sv =====
// ----------------------------------------------------------------------------
// aue_datapath
// Input capture, immediate encoding, literal pool memory and search pointer.
// ----------------------------------------------------------------------------
module aue_datapath import aue_pkg::*; #(
    parameter int POOL_WORDS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  aue_cmd_t    cmd,
    output aue_stat_t   stat,
    output logic        pool_full_flag,
    output logic        srch_hit,
    output logic        srch_end,
    input  logic [3:0]  s_action,
    input  logic [3:0]  s_dest_reg,
    input  logic [3:0]  s_src_a_reg,
    input  logic [3:0]  s_src_b_reg,
    input  logic [31:0] s_immediate,
    input  logic [3:0]  temp_reg,
    input  logic [3:0]  pool_base_reg,
    output logic [31:0] out_word,
    output logic [9:0]  out_index
);
    localparam int AW = $clog2(POOL_WORDS);
    localparam int CW = $clog2(POOL_WORDS + 1);

    logic [31:0] pool_mem [POOL_WORDS];
    logic [31:0] rd_data_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg;
    logic          rd_vld_reg;

    logic [31:0] direct_reg, lit_reg, val_next;
    logic [7:0]  opr_reg;
    logic [3:0]  rd_reg, rn_reg, ldr_dst_reg;
    aue_stat_t   stat_reg, stat_next;
    logic [31:0] direct_next;
    logic [7:0]  opr_next;

    // decode
    always_comb begin
        logic [31:0] imm;
        logic [3:0]  act;
        logic [12:0] e, eb;
        logic [7:0]  opi, opr;
        logic        bic;
        imm = s_immediate;
        act = s_action;
        opi = OPC_ADD_I;
        opr = OPC_ADD_R;
        bic = 1'b0;
        stat_next   = '0;
        direct_next = '0;
        opr_next    = OPC_ADD_R;
        val_next    = imm;
        if ((act == ACT_ADD_IMM || act == ACT_SUB_IMM) && imm[31] && imm != MIN_NEG) begin
            imm = 32'd0 - imm;
            act = (act == ACT_ADD_IMM) ? ACT_SUB_IMM : ACT_ADD_IMM;
        end
        unique case (act)
            ACT_ADD_IMM: begin opi = OPC_ADD_I; opr = OPC_ADD_R; end
            ACT_SUB_IMM: begin opi = OPC_SUB_I; opr = OPC_SUB_R; end
            ACT_AND_IMM: begin opi = OPC_AND_I; opr = OPC_AND_R; bic = 1'b1; end
            ACT_OR_IMM:  begin opi = OPC_ORR_I; opr = OPC_ORR_R; end
            ACT_XOR_IMM: begin opi = OPC_EOR_I; opr = OPC_EOR_R; end
            default: ;
        endcase
        e  = rot_imm(imm);
        eb = rot_imm(~imm);
        opr_next = opr;
        val_next = imm;
        unique case (act)
            ACT_MOV: begin
                stat_next.direct = 1'b1;
                direct_next = dp_word(OPC_MOV_R, s_dest_reg, 4'd0, {8'd0, s_src_a_reg});
            end
            ACT_MOV_IMM: begin
                if (e[12]) begin
                    stat_next.direct = 1'b1;
                    direct_next = dp_word(OPC_MOV_I, s_dest_reg, 4'd0, e[11:0]);
                end else begin
                    stat_next.need_lit = 1'b1;
                    stat_next.lit_to_d = 1'b1;
                end
            end
            ACT_ADD, ACT_AND, ACT_OR, ACT_SUB, ACT_XOR, ACT_ADD_LSH: begin
                stat_next.direct = 1'b1;
                unique case (act)
                    ACT_ADD, ACT_ADD_LSH: opr = OPC_ADD_R;
                    ACT_AND: opr = OPC_AND_R;
                    ACT_OR:  opr = OPC_ORR_R;
                    ACT_SUB: opr = OPC_SUB_R;
                    default: opr = OPC_EOR_R;
                endcase
                direct_next = dp_word(opr, s_dest_reg, s_src_a_reg,
                    {(act == ACT_ADD_LSH) ? s_immediate[4:0] : 5'd0, 3'd0, s_src_b_reg});
            end
            ACT_ADD_IMM, ACT_SUB_IMM, ACT_AND_IMM, ACT_OR_IMM, ACT_XOR_IMM: begin
                if (e[12]) begin
                    stat_next.direct = 1'b1;
                    direct_next = dp_word(opi, s_dest_reg, s_src_a_reg, e[11:0]);
                end else if (bic && eb[12]) begin
                    stat_next.direct = 1'b1;
                    direct_next = dp_word(OPC_BIC_I, s_dest_reg, s_src_a_reg, eb[11:0]);
                end else begin
                    stat_next.need_lit = 1'b1;
                end
            end
            default: stat_next.none = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            stat_reg    <= stat_next;
            direct_reg  <= direct_next;
            lit_reg     <= val_next;
            opr_reg     <= opr_next;
            rd_reg      <= s_dest_reg;
            rn_reg      <= s_src_a_reg;
            ldr_dst_reg <= stat_next.lit_to_d ? s_dest_reg : temp_reg;
        end
    end
    assign stat = stat_reg;

    // pool memory: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.append) pool_mem[count_reg[AW-1:0]] <= lit_reg;
        rd_data_reg <= pool_mem[ptr_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (cmd.clr_pool) count_reg <= '0;
            else if (cmd.append) count_reg <= count_reg + 1'b1;
            if (cmd.srch_start) begin
                ptr_reg    <= '0;
                rd_vld_reg <= 1'b0;
            end else if (cmd.srch_step) begin
                ptr_reg    <= ptr_reg + 1'b1;
                rd_vld_reg <= 1'b1;
            end else if (cmd.append) begin
                // stop comparing once the new literal lands, it would match itself
                rd_vld_reg <= 1'b0;
            end
        end
    end

    // read data for ptr-1 arrives while ptr advances; hit index is ptr-1
    logic [CW-1:0] hit_idx, lit_idx_reg;
    assign hit_idx  = ptr_reg - 1'b1;
    assign srch_hit = rd_vld_reg && (hit_idx < count_reg) && (rd_data_reg == lit_reg);
    assign srch_end = (ptr_reg >= count_reg) && !srch_hit;
    assign pool_full_flag = (count_reg >= CW'(POOL_WORDS));

    always_ff @(posedge aclk) begin
        if (srch_hit) lit_idx_reg <= hit_idx;
        else if (cmd.append) lit_idx_reg <= count_reg;
    end

    always_comb begin
        out_word  = '0;
        out_index = '0;
        unique case (cmd.sel)
            SEL_DIRECT: out_word = direct_reg;
            SEL_POOL: begin
                out_word  = lit_reg;
                out_index = 10'(lit_idx_reg);
            end
            SEL_LDR: out_word = {COND_AL, OPC_LDR_I, 20'd0} | LDR_UP |
                {12'd0, pool_base_reg, ldr_dst_reg, 12'(lit_idx_reg) << 2};
            default: out_word = '0;
        endcase
        if (cmd.sel == SEL_DIRECT && stat_reg.need_lit)
            out_word = dp_word(opr_reg, rd_reg, rn_reg, {8'd0, temp_reg});
    end
endmodule

// ===== rtl/aue_ctrl.sv =====
// ----------------------------------------------------------------------------
// aue_ctrl
// Sequencer: decode, pool search for literal ops, then result beats.
// ----------------------------------------------------------------------------
module aue_ctrl import aue_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic [3:0] s_action,
    input  aue_stat_t stat,
    input  logic      pool_full_flag,
    input  logic      srch_hit,
    input  logic      srch_end,
    output aue_cmd_t  cmd,
    output logic      out_valid,
    input  logic      out_ready
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_SRCH = 3'd2;
    localparam logic [2:0] ST_POOL = 3'd3;
    localparam logic [2:0] ST_LDR  = 3'd4;
    localparam logic [2:0] ST_OP   = 3'd5;
    localparam logic [2:0] ST_FULL = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        out_valid  = 1'b0;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: if (s_valid) begin
                cmd.load = 1'b1;
                cmd.clr_pool = (s_action == ACT_RESET);
                cmd.srch_start = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                priority if (stat.none) state_next = ST_IDLE;
                else if (stat.direct) state_next = ST_OP;
                else if (pool_full_flag) state_next = ST_FULL;
                else begin
                    cmd.srch_step = 1'b1;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                priority if (srch_hit) state_next = ST_LDR;
                else if (srch_end) begin
                    cmd.append = 1'b1;
                    state_next = ST_POOL;
                end else cmd.srch_step = 1'b1;
            end
            ST_POOL: begin
                cmd.sel = SEL_POOL;
                out_valid = 1'b1;
                if (out_ready) state_next = ST_LDR;
            end
            ST_LDR: begin
                cmd.sel = SEL_LDR;
                cmd.last = stat.lit_to_d;
                out_valid = 1'b1;
                if (out_ready) state_next = stat.lit_to_d ? ST_IDLE : ST_OP;
            end
            ST_OP: begin
                cmd.sel = SEL_DIRECT;
                cmd.last = 1'b1;
                out_valid = 1'b1;
                if (out_ready) state_next = ST_IDLE;
            end
            ST_FULL: begin
                cmd.sel = SEL_FULL;
                cmd.last = 1'b1;
                out_valid = 1'b1;
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.emit = out_valid;
    end
endmodule

// ===== rtl/arm_alu_uop_encoder_literal_pool_core.sv =====
// ----------------------------------------------------------------------------
// arm_alu_uop_encoder_literal_pool_core
// ALU micro-op to ARM word encoder with a deduplicating literal pool.
// ----------------------------------------------------------------------------
// Sequence: direct encodings go from decode straight to their beat; literal ops
//   first search the pool, the search reading one pool entry
//   per cycle (one RAM port).
// Throughput: one micro-op at a time; s_ready is high only in idle, so a new op
//   waits until the previous one has finished, including any output stalls.
// Reset: synchronous active-low aresetn; pool emptied (count to zero),
//   temp_reg=12, pool_base_reg=11. Pool RAM contents are not cleared.
module arm_alu_uop_encoder_literal_pool_core import aue_pkg::*; #(
    parameter int POOL_WORDS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beat
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_action,
    input  logic [3:0]  s_dest_reg,
    input  logic [3:0]  s_src_a_reg,
    input  logic [3:0]  s_src_b_reg,
    input  logic [31:0] s_immediate,
    // result beat
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [31:0] m_word,
    output logic [9:0]  m_pool_index,
    output logic        m_pool_full,
    output logic        m_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [3:0] temp_reg_reg, pool_base_reg_reg;
    aue_cmd_t   cmd;
    aue_stat_t  stat;
    logic       pool_full_flag, srch_hit, srch_end;
    logic [31:0] dp_word_w;
    logic [9:0]  dp_index;

    // configuration registers, word address = paddr[2]
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg_reg      <= 4'd12;
            pool_base_reg_reg <= 4'd11;
        end else if (psel && penable && pwrite) begin
            if ({3'd0, paddr[2]} == CFG_TEMP_REG) temp_reg_reg <= pwdata[3:0];
            if ({3'd0, paddr[2]} == CFG_POOL_REG) pool_base_reg_reg <= pwdata[3:0];
        end
    end
    always_comb begin
        prdata = '0;
        if ({3'd0, paddr[2]} == CFG_TEMP_REG) prdata = {28'd0, temp_reg_reg};
        else prdata = {28'd0, pool_base_reg_reg};
    end

    aue_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_action,
        .stat, .pool_full_flag, .srch_hit, .srch_end, .cmd,
        .out_valid(m_valid), .out_ready(m_ready)
    );

    aue_datapath #(.POOL_WORDS(POOL_WORDS)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .pool_full_flag, .srch_hit, .srch_end,
        .s_action, .s_dest_reg, .s_src_a_reg, .s_src_b_reg, .s_immediate,
        .temp_reg(temp_reg_reg), .pool_base_reg(pool_base_reg_reg),
        .out_word(dp_word_w), .out_index(dp_index)
    );

    // beat fields follow the controller's word select; held while stalled
    assign m_word       = dp_word_w;
    assign m_pool_index = dp_index;
    assign m_kind       = (cmd.sel == SEL_POOL);
    assign m_pool_full  = (cmd.sel == SEL_FULL);
    assign m_last       = cmd.last;

    // a pool beat is never the last of its op
    a_pool_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind |-> !m_last) else $error("pool beat flagged last");
    // no new op accepted while a beat is pending
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input accepted during output");
    // a full flag never accompanies a pool beat and always marks the last beat
    a_full_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pool_full |-> !m_kind && m_last) else $error("bad full beat");
endmodule
